// ----- rtl/core/tert_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tert_pkg
// Shared sizes, opcodes and word types for the timed edge reservation table.
// ----------------------------------------------------------------------------
package tert_pkg;

  localparam int ENTRIES      = 16;
  localparam int NODE_ID_BITS = 16;
  localparam int TIME_BITS    = 48;
  localparam int OP_BITS      = 3;
  localparam int OCC_BITS     = 5;
  localparam int IDX_BITS     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_BITS     = $clog2(ENTRIES + 1);

  localparam logic [OP_BITS-1:0] OP_ADD    = 3'd0;
  localparam logic [OP_BITS-1:0] OP_REMOVE = 3'd1;
  localparam logic [OP_BITS-1:0] OP_CLEAR  = 3'd2;
  localparam logic [OP_BITS-1:0] OP_EXPIRE = 3'd3;
  localparam logic [OP_BITS-1:0] OP_QUERY  = 3'd4;

  typedef struct packed {
    logic [NODE_ID_BITS-1:0] from_node;
    logic [NODE_ID_BITS-1:0] to_node;
    logic [TIME_BITS-1:0]    expiry;
  } entry_t;

  typedef struct packed {
    logic                we;
    logic [IDX_BITS-1:0] addr;
    entry_t              data;
  } wr_t;

  typedef struct packed {
    logic fwd;
    logic rev;
    logic old;
  } cmp_t;

  typedef struct packed {
    logic                blocked;
    logic                present;
    logic                changed;
    logic                full_refused;
    logic [OCC_BITS-1:0] occupancy;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/core/tert_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tert_store
// Entry memory: node pair and expiry per slot, one write and one registered
// read per cycle.
// ----------------------------------------------------------------------------
module tert_store
  import tert_pkg::*;
(
  input  wire logic                clk,
  input  wire wr_t                 wr,
  input  wire logic [IDX_BITS-1:0] rd_addr,
  output entry_t                   rd_data
);

  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/tert_cmp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tert_cmp
// Shared compare unit: matches one stored entry against the request pair in
// both directions and checks its expiry against the request time.
// ----------------------------------------------------------------------------
module tert_cmp
  import tert_pkg::*;
(
  input  wire entry_t                  entry,
  input  wire logic [NODE_ID_BITS-1:0] a,
  input  wire logic [NODE_ID_BITS-1:0] b,
  input  wire logic [TIME_BITS-1:0]    t,
  output cmp_t                         cmp
);

  always_comb begin
    cmp.fwd = (entry.from_node == a) && (entry.to_node == b);
    cmp.rev = (entry.from_node == b) && (entry.to_node == a);
    cmp.old = (entry.expiry < t);
  end

endmodule

`default_nettype wire

// ----- rtl/core/tert_seq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tert_seq
// Sequencer: scans all slots through the shared compare unit, one per cycle,
// then applies the operation and hands over one result word.
// ----------------------------------------------------------------------------
module tert_seq
  import tert_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [OP_BITS-1:0]      op_in,
  input  wire logic [NODE_ID_BITS-1:0] a_in,
  input  wire logic [NODE_ID_BITS-1:0] b_in,
  input  wire logic [TIME_BITS-1:0]    t_in,
  output logic                         busy,
  output logic [IDX_BITS-1:0]          rd_addr,
  input  wire entry_t                  rd_data,
  output wr_t                          wr,
  input  wire logic                    res_ready,
  output logic                         res_load,
  output res_t                         res
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_APPLY = 2'd3;

  logic [1:0]              state;
  logic [OP_BITS-1:0]      op;
  logic [NODE_ID_BITS-1:0] a;
  logic [NODE_ID_BITS-1:0] b;
  logic [TIME_BITS-1:0]    t;
  logic [IDX_BITS-1:0]     idx;
  logic                    pend;
  logic [IDX_BITS-1:0]     pend_idx;
  logic                    hit_fwd;
  logic [IDX_BITS-1:0]     hit_idx;
  logic                    hit_rev;
  logic                    free_found;
  logic [IDX_BITS-1:0]     free_idx;
  logic [ENTRIES-1:0]      valid;
  logic [ENTRIES-1:0]      valid_next;
  logic [CNT_BITS-1:0]     count;
  logic [CNT_BITS-1:0]     count_next;
  logic                    modified;
  logic                    modified_next;
  logic                    vld;
  cmp_t                    cmp;

  tert_cmp u_cmp (
    .entry (rd_data),
    .a     (a),
    .b     (b),
    .t     (t),
    .cmp   (cmp)
  );

  assign busy    = (state != S_IDLE);
  assign rd_addr = idx;
  assign vld     = valid[pend_idx];

  always_comb begin
    valid_next    = valid;
    count_next    = count;
    modified_next = modified;
    wr            = '0;
    res           = '0;
    res_load      = 1'b0;
    // expire drops are taken during the scan
    if (pend && (op == OP_EXPIRE) && vld && cmp.old) begin
      valid_next[pend_idx] = 1'b0;
      count_next           = count - CNT_BITS'(1);
      modified_next        = 1'b1;
    end
    if ((state == S_APPLY) && res_ready) begin
      res_load = 1'b1;
      case (op)
        OP_ADD: begin
          if (!hit_fwd) begin
            if (free_found) begin
              wr.we                = 1'b1;
              wr.addr              = free_idx;
              wr.data.from_node    = a;
              wr.data.to_node      = b;
              wr.data.expiry       = t;
              valid_next[free_idx] = 1'b1;
              count_next           = count + CNT_BITS'(1);
              modified_next        = 1'b1;
            end else begin
              res.full_refused = 1'b1;
            end
          end
        end
        OP_REMOVE: begin
          if (hit_fwd) begin
            valid_next[hit_idx] = 1'b0;
            count_next          = count - CNT_BITS'(1);
            modified_next       = 1'b1;
          end
        end
        OP_CLEAR: begin
          if (count != '0) begin
            valid_next    = '0;
            count_next    = '0;
            modified_next = 1'b1;
          end
        end
        OP_EXPIRE: begin
          res.changed   = modified;
          modified_next = 1'b0;
        end
        OP_QUERY: begin
          res.present = hit_fwd;
          res.blocked = hit_fwd | hit_rev;
        end
        default: begin
        end
      endcase
      res.occupancy = OCC_BITS'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      valid    <= '0;
      count    <= '0;
      modified <= 1'b0;
      pend     <= 1'b0;
      idx      <= '0;
    end else begin
      valid    <= valid_next;
      count    <= count_next;
      modified <= modified_next;
      pend     <= (state == S_SCAN);
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_SCAN;
            idx   <= '0;
          end
        end
        S_SCAN: begin
          if (idx == IDX_BITS'(ENTRIES - 1)) begin
            state <= S_DRAIN;
          end else begin
            idx <= idx + IDX_BITS'(1);
          end
        end
        S_DRAIN: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request capture and scan bookkeeping
  always_ff @(posedge clk) begin
    pend_idx <= idx;
    if ((state == S_IDLE) && start) begin
      op         <= op_in;
      a          <= a_in;
      b          <= b_in;
      t          <= t_in;
      hit_fwd    <= 1'b0;
      hit_rev    <= 1'b0;
      free_found <= 1'b0;
      hit_idx    <= '0;
      free_idx   <= '0;
    end else if (pend) begin
      if (vld && cmp.fwd && !hit_fwd) begin
        hit_fwd <= 1'b1;
        hit_idx <= pend_idx;
      end
      if (vld && cmp.rev) begin
        hit_rev <= 1'b1;
      end
      if (!vld && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= pend_idx;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/timed_edge_reservation_table_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// timed_edge_reservation_table_top
// Bounded table of reserved directed edges with expiry times: add, remove,
// clear, expire and query, one result word per request word.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   opcode from_node to_node time_value
//   rsp      out        rsp_valid/rsp_stall   blocked present changed
//                                             full_refused occupancy
//
// A request is taken only while the sequencer is idle: one slot per cycle goes
// through the shared compare unit, then one drain and one apply step, then
// one idle step in which the next request is taken.
// The result word is loaded into the output register in the apply step.
// Synchronous reset empties the table and clears the changed flag.
// A result waits in the output register under rsp_stall; the next request is
// taken meanwhile, and its apply step holds until that register frees.
// ----------------------------------------------------------------------------
module timed_edge_reservation_table_top
  import tert_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    req_valid,
  output logic                         req_stall,
  input  wire logic [OP_BITS-1:0]      opcode,
  input  wire logic [NODE_ID_BITS-1:0] from_node,
  input  wire logic [NODE_ID_BITS-1:0] to_node,
  input  wire logic [TIME_BITS-1:0]    time_value,
  output logic                         rsp_valid,
  input  wire logic                    rsp_stall,
  output logic                         blocked,
  output logic                         present,
  output logic                         changed,
  output logic                         full_refused,
  output logic [OCC_BITS-1:0]          occupancy
);

  logic                busy;
  logic [IDX_BITS-1:0] rd_addr;
  entry_t              rd_data;
  wr_t                 wr;
  logic                res_ready;
  logic                res_load;
  res_t                res;

  assign req_stall = rst | busy;
  assign res_ready = !rsp_valid || !rsp_stall;

  tert_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tert_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (req_valid && !req_stall),
    .op_in     (opcode),
    .a_in      (from_node),
    .b_in      (to_node),
    .t_in      (time_value),
    .busy      (busy),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr        (wr),
    .res_ready (res_ready),
    .res_load  (res_load),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      blocked      <= res.blocked;
      present      <= res.present;
      changed      <= res.changed;
      full_refused <= res.full_refused;
      occupancy    <= res.occupancy;
    end
  end

  a_present_blocked: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && present |-> blocked)
    else $error("present without blocked");

  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> $countones({changed, full_refused, blocked}) <= 1)
    else $error("flags of different operations together");

  a_refused_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && full_refused |-> occupancy == OCC_BITS'(ENTRIES))
    else $error("add refused while table not full");

  a_no_result_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !res_load)
    else $error("result word while sequencer idle");

endmodule

`default_nettype wire
